FILE: design/crrt_pkg.sv
// shared types and constants for the client resource reservation table
// no dependencies; imported by every module of the block
package crrt_pkg;

	localparam int MAX_CLIENTS = 16;
	localparam int ID_W        = 16;
	localparam int CPU_W       = 10;
	localparam int MEM_W       = 20;
	localparam int USED_W      = 5;
	localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CPU_W-1:0] CPU_MAX = '1;
	localparam logic [MEM_W-1:0] MEM_MAX = '1;

	// operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CPU    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEMORY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_RES     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;

	// data rippling from one cell to the next
	typedef struct packed {
		logic             hit;
		logic [CPU_W-1:0] cpu;
		logic [MEM_W-1:0] mem;
		logic             free_seen;
	} link_t;

	// command broadcast to every cell
	typedef struct packed {
		logic             look;
		logic             add;
		logic             open;
		logic             clear;
		logic [ID_W-1:0]  id;
		logic [CPU_W-1:0] cpu;
		logic [MEM_W-1:0] mem;
	} cmd_t;

endpackage

FILE: design/crrt_cell.sv
// one table entry with its id match, first-free flag and commit update
// depends on crrt_pkg
module crrt_cell import crrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  link_t link_prev,
	output link_t link_next
);

	logic             valid_q;
	logic [ID_W-1:0]  client_q;
	logic [CPU_W-1:0] cpu_q;
	logic [MEM_W-1:0] mem_q;
	logic             hit_q;
	logic             first_free_q;

	logic             my_hit;
	logic             my_first_free;
	logic [CPU_W:0]   cpu_sum;
	logic [MEM_W:0]   mem_sum;

	assign my_hit        = valid_q && (client_q == cmd.id);
	assign my_first_free = !valid_q && !link_prev.free_seen;

	assign link_next.hit       = link_prev.hit | my_hit;
	assign link_next.cpu       = link_prev.cpu | (my_hit ? cpu_q : '0);
	assign link_next.mem       = link_prev.mem | (my_hit ? mem_q : '0);
	assign link_next.free_seen = link_prev.free_seen | !valid_q;

	assign cpu_sum = {1'b0, cpu_q} + {1'b0, cmd.cpu};
	assign mem_sum = {1'b0, mem_q} + {1'b0, cmd.mem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			hit_q        <= 1'b0;
			first_free_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				hit_q        <= my_hit;
				first_free_q <= my_first_free;
			end
			if (cmd.open && first_free_q) begin
				valid_q <= 1'b1;
			end else if (cmd.clear && hit_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && hit_q) begin
			cpu_q <= cpu_sum[CPU_W] ? CPU_MAX : cpu_sum[CPU_W-1:0];
			mem_q <= mem_sum[MEM_W] ? MEM_MAX : mem_sum[MEM_W-1:0];
		end else if (cmd.open && first_free_q) begin
			client_q <= cmd.id;
			cpu_q    <= cmd.cpu;
			mem_q    <= cmd.mem;
		end
	end

endmodule

FILE: design/crrt_chain.sv
// row of entry cells, the match and free search rippling left to right
// depends on crrt_pkg and crrt_cell
module crrt_chain import crrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output link_t summary
);

	link_t links [MAX_CLIENTS+1];

	assign links[0] = '0;

	for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
		crrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.link_prev (links[i]),
			.link_next (links[i+1])
		);
	end

	assign summary = links[MAX_CLIENTS];

endmodule

FILE: design/client_resource_reservation_table.sv
// client resource reservation table: pool bookkeeping and a chain of entry cells
// done is registered and rises with the result once the request has passed the look and commit states
// a new request can be taken in the result cycle, but not while the block is busy
// busy is high for the look and commit cycles; results cannot be stalled by the receiver
// reset clears all entries and loads zero pools; configuration writes reload the pools
// depends on crrt_pkg and crrt_chain
module client_resource_reservation_table import crrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// request transaction
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [ID_W-1:0]      client_id,
	input  logic [CPU_W-1:0]     cpu_request,
	input  logic [MEM_W-1:0]     memory_request,
	// result transaction
	output logic                 done,
	output logic [1:0]           status,
	output logic [CPU_W-1:0]     cpu_left,
	output logic [MEM_W-1:0]     memory_left,
	output logic [USED_W-1:0]    entries_used,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MEM_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOK   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;

	// request held for the whole transaction
	logic             func_q;
	logic [ID_W-1:0]  id_q;
	logic [CPU_W-1:0] req_cpu_q;
	logic [MEM_W-1:0] req_mem_q;

	// outcome of the chain search, captured at the end of the look cycle
	logic             hit_q;
	logic [CPU_W-1:0] hit_cpu_q;
	logic [MEM_W-1:0] hit_mem_q;
	logic             free_any_q;

	logic [CPU_W-1:0] pool_cpu_q;
	logic [MEM_W-1:0] pool_mem_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;
	logic             done_q;

	cmd_t  cmd;
	link_t summary;

	logic             accept;
	logic             short_res;
	logic             do_add;
	logic             do_open;
	logic             do_clear;
	logic [1:0]       status_next;
	logic [CPU_W:0]   ret_cpu;
	logic [MEM_W:0]   ret_mem;
	logic [CNT_W+USED_W-1:0] count_ext;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	// configuration is to be written only while idle; the block does not enforce this, so no back-pressure is needed
	assign cfg_ready = 1'b1;

	// decision logic, used in the commit cycle
	assign short_res = (req_cpu_q > pool_cpu_q) || (req_mem_q > pool_mem_q);

	always_comb begin
		do_add      = 1'b0;
		do_open     = 1'b0;
		do_clear    = 1'b0;
		status_next = ST_OK;
		case (func_q)
			FUNC_ALLOC: begin
				if (short_res) begin
					status_next = ST_NO_RES;
				end else if (hit_q) begin
					do_add = 1'b1;
				end else if (free_any_q) begin
					do_open = 1'b1;
				end else begin
					status_next = ST_TABLE_FULL;
				end
			end
			FUNC_FREE: begin
				if (hit_q) begin
					do_clear = 1'b1;
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	// broadcast to the cells: search in the look cycle, update in the commit cycle
	always_comb begin
		cmd.look  = (state_q == ST_LOOK);
		cmd.add   = (state_q == ST_COMMIT) && do_add;
		cmd.open  = (state_q == ST_COMMIT) && do_open;
		cmd.clear = (state_q == ST_COMMIT) && do_clear;
		cmd.id    = id_q;
		cmd.cpu   = req_cpu_q;
		cmd.mem   = req_mem_q;
	end

	crrt_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.summary (summary)
	);

	// amounts given back on free saturate at the field maximum
	assign ret_cpu = {1'b0, pool_cpu_q} + {1'b0, hit_cpu_q};
	assign ret_mem = {1'b0, pool_mem_q} + {1'b0, hit_mem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pool_cpu_q <= '0;
			pool_mem_q <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (do_add || do_open) begin
						pool_cpu_q <= pool_cpu_q - req_cpu_q;
						pool_mem_q <= pool_mem_q - req_mem_q;
					end
					if (do_clear) begin
						pool_cpu_q <= ret_cpu[CPU_W] ? CPU_MAX : ret_cpu[CPU_W-1:0];
						pool_mem_q <= ret_mem[MEM_W] ? MEM_MAX : ret_mem[MEM_W-1:0];
						count_q    <= count_q - 1'b1;
					end
					if (do_open) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// register write reloads the matching pool
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOTAL_CPU:    pool_cpu_q <= cfg_data[CPU_W-1:0];
					REG_TOTAL_MEMORY: pool_mem_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			id_q      <= client_id;
			req_cpu_q <= cpu_request;
			req_mem_q <= memory_request;
		end
		if (state_q == ST_LOOK) begin
			hit_q      <= summary.hit;
			hit_cpu_q  <= summary.cpu;
			hit_mem_q  <= summary.mem;
			free_any_q <= summary.free_seen;
		end
		if (state_q == ST_COMMIT) begin
			status_q <= status_next;
		end
	end

	// result outputs
	assign count_ext    = {{USED_W{1'b0}}, count_q};
	assign done         = done_q;
	assign status       = status_q;
	assign cpu_left     = pool_cpu_q;
	assign memory_left  = pool_mem_q;
	assign entries_used = count_ext[USED_W-1:0];

endmodule

FILE: tb/tb.sv
// self-checking testbench for client_resource_reservation_table
// predicts pool, table and status per request and compares every result strobe
// depends on crrt_pkg and the block's rtl only
module tb;
	import crrt_pkg::*;

	// one expected result transaction
	typedef struct packed {
		logic [1:0]        status;
		logic [CPU_W-1:0]  cpu_left;
		logic [MEM_W-1:0]  memory_left;
		logic [USED_W-1:0] entries_used;
	} booking_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request side
	logic             start = 1'b0;
	logic             busy;
	logic             func = FUNC_ALLOC;
	logic [ID_W-1:0]  client_id = '0;
	logic [CPU_W-1:0] cpu_request = '0;
	logic [MEM_W-1:0] memory_request = '0;

	// result side
	logic              done;
	logic [1:0]        status;
	logic [CPU_W-1:0]  cpu_left;
	logic [MEM_W-1:0]  memory_left;
	logic [USED_W-1:0] entries_used;

	// configuration channel
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TOTAL_CPU;
	logic [MEM_W-1:0]     cfg_data = '0;

	// predicted block state, matches the block after reset
	logic [CPU_W-1:0] avail_cpu = '0;
	logic [MEM_W-1:0] avail_mem = '0;
	logic             slot_taken [MAX_CLIENTS];
	logic [ID_W-1:0]  slot_owner [MAX_CLIENTS];
	logic [CPU_W-1:0] slot_cpu [MAX_CLIENTS];
	logic [MEM_W-1:0] slot_mem [MAX_CLIENTS];

	booking_t        pending_bookings[$];
	int              errors = 0;
	bit              start_held = 1'b0;
	logic [ID_W-1:0] id_set [24];

	client_resource_reservation_table uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.client_id      (client_id),
		.cpu_request    (cpu_request),
		.memory_request (memory_request),
		.done           (done),
		.status         (status),
		.cpu_left       (cpu_left),
		.memory_left    (memory_left),
		.entries_used   (entries_used),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			slot_taken[i] = 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic int unsigned clip_sum(input int unsigned a, input int unsigned b,
			input int unsigned lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	// slot holding this client, or -1
	function automatic int owner_slot(input logic [ID_W-1:0] id);
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			if (slot_taken[i] && slot_owner[i] == id) return i;
		end
		return -1;
	endfunction

	// lowest empty slot, or -1
	function automatic int empty_slot();
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			if (!slot_taken[i]) return i;
		end
		return -1;
	endfunction

	function automatic logic [USED_W-1:0] slots_in_use();
		int n;
		n = 0;
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			if (slot_taken[i]) n++;
		end
		return USED_W'(n);
	endfunction

	// applies one accepted request to the predicted state and queues its result
	task automatic book_request(input logic op, input logic [ID_W-1:0] id,
			input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem);
		booking_t res;
		int       hit;
		int       gap;
		res.status = ST_OK;
		hit = owner_slot(id);
		if (op == FUNC_ALLOC) begin
			// resources are checked before the table is even looked at
			if (cpu > avail_cpu || mem > avail_mem) begin
				res.status = ST_NO_RES;
			end else if (hit >= 0) begin
				// top-up of an existing reservation saturates per entry
				slot_cpu[hit] = CPU_W'(clip_sum(slot_cpu[hit], cpu, CPU_MAX));
				slot_mem[hit] = MEM_W'(clip_sum(slot_mem[hit], mem, MEM_MAX));
			end else begin
				gap = empty_slot();
				if (gap >= 0) begin
					slot_taken[gap] = 1'b1;
					slot_owner[gap] = id;
					slot_cpu[gap]   = cpu;
					slot_mem[gap]   = mem;
				end else begin
					res.status = ST_TABLE_FULL;
				end
			end
			if (res.status == ST_OK) begin
				avail_cpu = avail_cpu - cpu;
				avail_mem = avail_mem - mem;
			end
		end else begin
			// request amounts play no part in a free
			if (hit < 0) begin
				res.status = ST_NOT_FOUND;
			end else begin
				avail_cpu = CPU_W'(clip_sum(avail_cpu, slot_cpu[hit], CPU_MAX));
				avail_mem = MEM_W'(clip_sum(avail_mem, slot_mem[hit], MEM_MAX));
				slot_taken[hit] = 1'b0;
			end
		end
		res.cpu_left     = avail_cpu;
		res.memory_left  = avail_mem;
		res.entries_used = slots_in_use();
		pending_bookings.push_back(res);
	endtask

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// start stays high between back-to-back requests, lowered only here
	task automatic release_start();
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
	endtask

	// one request transaction; returns on the edge that accepted it
	task automatic send_request(input logic op, input logic [ID_W-1:0] id,
			input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem);
		start          <= 1'b1;
		func           <= op;
		client_id      <= id;
		cpu_request    <= cpu;
		memory_request <= mem;
		start_held = 1'b1;
		do @(posedge clk); while (busy);
		book_request(op, id, cpu, mem);
	endtask

	task automatic hold_off(input int cycles);
		release_start();
		repeat (cycles) @(posedge clk);
	endtask

	// wait until every queued result is back, then let the block go quiet
	task automatic settle();
		release_start();
		while (pending_bookings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high so consecutive writes need no gap
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [MEM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		// a write reloads the pool and leaves the table alone
		if (idx == REG_TOTAL_CPU) begin
			avail_cpu = data[CPU_W-1:0];
		end else if (idx == REG_TOTAL_MEMORY) begin
			avail_mem = data;
		end
	endtask

	// only called once the block is idle
	task automatic set_totals(input logic [CPU_W-1:0] cpu_total,
			input logic [MEM_W-1:0] mem_total);
		logic [MEM_W-1:0] word;
		// junk in the unused upper bits of the cpu write
		word = MEM_W'($urandom());
		word[CPU_W-1:0] = cpu_total;
		write_register(REG_TOTAL_CPU, word);
		write_register(REG_TOTAL_MEMORY, mem_total);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
			errors++;
		end
	endtask

	// done is sampled at the edge that ends its cycle
	always @(posedge clk) begin
		booking_t want;
		if (arst_n && done) begin
			if (pending_bookings.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0d",
					$realtime, status);
				errors++;
			end else begin
				want = pending_bookings.pop_front();
				check_field("status", want.status, status);
				check_field("cpu_left", want.cpu_left, cpu_left);
				check_field("memory_left", want.memory_left, memory_left);
				check_field("entries_used", want.entries_used, entries_used);
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// pools are zero out of reset
	task automatic test_empty_pool();
		// zero amounts are granted and still open an entry
		send_request(FUNC_ALLOC, 16'h0000, '0, '0);
		// cpu alone does not fit
		send_request(FUNC_ALLOC, 16'h1234, 10'd1, '0);
		// memory alone does not fit
		send_request(FUNC_ALLOC, 16'h4321, '0, 20'd1);
		// free of a client with no entry
		send_request(FUNC_FREE, 16'hBEEF, '0, '0);
	endtask

	// entry and pool saturation, reachable only through a pool reload
	task automatic test_saturation();
		settle();
		set_totals(CPU_MAX, MEM_MAX);
		send_request(FUNC_ALLOC, 16'hFFFF, 10'd1000, 20'd1000000);
		settle();
		set_totals(CPU_MAX, MEM_MAX);
		// the top-up clips the entry at full scale
		send_request(FUNC_ALLOC, 16'hFFFF, 10'd1000, 20'd1000000);
		// returning a full entry clips the pool, request fields ignored
		send_request(FUNC_FREE, 16'hFFFF, CPU_MAX, MEM_MAX);
	endtask

	// fill the table behind client 0, one bit of the id per client
	task automatic test_table_full();
		for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
			send_request(FUNC_ALLOC, ID_W'(1) << i, CPU_W'(i + 1), MEM_W'((i + 1) * 1000));
		end
		// fits the pool but no slot is left
		send_request(FUNC_ALLOC, 16'h8000, 10'd1, 20'd1);
		// shortage wins over a full table
		send_request(FUNC_ALLOC, 16'h8000, CPU_MAX, 20'd1);
	endtask

	// a small id set makes hits, top-ups and a full table common
	task automatic pick_ids();
		id_set[0] = 16'h0000;
		id_set[1] = 16'hFFFF;
		for (int i = 2; i < 24; i++) begin
			id_set[i] = ID_W'($urandom());
		end
	endtask

	task automatic run_phase(input int items, input bit with_gaps);
		logic             op;
		logic [ID_W-1:0]  id;
		logic [CPU_W-1:0] cpu;
		logic [MEM_W-1:0] mem;
		for (int n = 0; n < items; n++) begin
			op = ($urandom_range(0, 9) < 6) ? FUNC_ALLOC : FUNC_FREE;
			id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom()) : id_set[$urandom_range(0, 23)];
			case ($urandom_range(0, 9))
				0: begin
					cpu = '0;
					mem = '0;
				end
				1, 2: begin
					// full range, mostly refused
					cpu = CPU_W'($urandom());
					mem = MEM_W'($urandom());
				end
				3: begin
					// memory side decides
					cpu = '0;
					mem = MEM_W'($urandom());
				end
				default: begin
					// sized to the pool so most are granted
					cpu = CPU_W'($urandom_range(0, avail_cpu / 4 + 1));
					mem = MEM_W'($urandom_range(0, avail_mem / 4 + 1));
				end
			endcase
			send_request(op, id, cpu, mem);
			if (with_gaps && $urandom_range(0, 4) == 0) begin
				hold_off($urandom_range(1, 11));
			end
		end
	endtask

	// each phase reloads the pools under a live table, so frees may clip
	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: set_totals(CPU_MAX, MEM_MAX);
				1: set_totals(CPU_W'($urandom_range(20, 60)), MEM_W'($urandom_range(500, 2000)));
				2: set_totals(CPU_W'($urandom()), MEM_W'($urandom()));
				3: set_totals(CPU_MAX, MEM_W'($urandom_range(0, 15)));
				4: set_totals(CPU_W'($urandom_range(0, 3)), MEM_MAX);
				default: set_totals(CPU_MAX, MEM_MAX);
			endcase
			pick_ids();
			// phase 2 runs back to back, the last phase has no gaps at all
			run_phase(300, p != 2 && p != 5);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pool();
		test_saturation();
		test_table_full();
		test_random_traffic();
		settle();
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
